// File: sv/mlp3s_pkg.sv
// Shared constants, types and single-precision arithmetic functions for the
// three-input sigmoid perceptron. Depends on nothing; imported by the top level.
package mlp3s_pkg;

	// Network dimensions and the layout of the weight memory.
	localparam int MAX_HIDDEN  = 16;
	localparam int INPUT_COUNT = 3;
	localparam int HW_DEPTH    = INPUT_COUNT * MAX_HIDDEN;
	localparam int HB_BASE     = HW_DEPTH;
	localparam int OW_BASE     = HB_BASE + MAX_HIDDEN;
	localparam int RAM_DEPTH   = OW_BASE + MAX_HIDDEN;
	localparam int RAM_AW      = $clog2(RAM_DEPTH);
	localparam int CNT_W       = $clog2(MAX_HIDDEN + 1);

	// Command and entry kind codes of an input word.
	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_PREDICT = 1'b1;

	typedef enum logic [1:0] {
		KIND_HID_WEIGHT = 2'd0,
		KIND_HID_BIAS   = 2'd1,
		KIND_OUT_WEIGHT = 2'd2,
		KIND_OUT_BIAS   = 2'd3
	} kind_t;

	// Register index carried by the word-address bit of the APB port.
	localparam logic REG_HIDDEN_COUNT = 1'b0;
	localparam logic [4:0] HIDDEN_COUNT_RESET = 5'd8;

	// Single-precision constants.
	localparam logic [31:0] F_ZERO    = 32'h0000_0000;
	localparam logic [31:0] F_ONE     = 32'h3F80_0000;
	localparam logic [31:0] F_HALF    = 32'h3F00_0000;
	localparam logic [31:0] F_NHALF   = 32'hBF00_0000;
	localparam logic [31:0] F_LOG2E   = 32'h3FB8_AA3B;
	localparam logic [31:0] F_LN2_HI  = 32'h3F31_7200;
	localparam logic [31:0] F_LN2_LO  = 32'h35BF_BE8E;
	localparam logic [31:0] F_EXP_MAX = 32'h42B1_7213;
	localparam logic [31:0] F_EXP_MIN = 32'hC2D0_0000;
	localparam logic [31:0] F_INF     = 32'h7F80_0000;
	localparam logic [31:0] F_DEF_NAN = 32'hFFC0_0000;
	localparam logic [31:0] F_C720    = 32'h3AB6_0B61;
	localparam logic [31:0] F_P2_127  = 32'h7F00_0000;
	localparam logic [31:0] F_P2_M126 = 32'h0080_0000;
	localparam logic [22:0] F_QUIET   = 23'h40_0000;

	// Unpacked operand with a normalized 24-bit significand.
	typedef struct packed {
		logic [23:0]        m;
		logic signed [9:0]  e;
	} unp_t;

	function automatic logic f_is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	// Round to nearest even and pack. sig holds the leading one at bit 25,
	// the value is sig/2^25 * 2^(exp-127); low-exponent results denormalize.
	function automatic logic [31:0] f_pack(input logic sign, input logic signed [9:0] exp,
			input logic [25:0] sig, input logic sticky);
		logic [9:0]  sh;
		logic [51:0] ext;
		logic [25:0] sd;
		logic [30:0] fld;
		logic        g;
		logic        st;
		logic        up;
		if (exp >= 10'sd255) begin
			return {sign, 8'hFF, 23'd0};
		end
		if (exp >= 10'sd1) begin
			fld = {exp[7:0], sig[24:2]};
			g   = sig[1];
			st  = sig[0] | sticky;
		end else begin
			sh = 10'(10'sd1 - exp);
			if (sh > 10'd26)
				sh = 10'd26;
			ext = {sig, 26'd0} >> sh;
			sd  = ext[51:26];
			fld = {8'd0, sd[24:2]};
			g   = sd[1];
			st  = sd[0] | (|ext[25:0]) | sticky;
		end
		up = g & (st | fld[0]);
		return {sign, fld + {30'd0, up}};
	endfunction

	// Unpack with subnormals normalized.
	function automatic unp_t f_norm(input logic [31:0] a);
		logic [23:0] m;
		logic [4:0]  lz;
		unp_t        u;
		m  = {a[30:23] != 8'd0, a[22:0]};
		lz = 5'd0;
		for (int i = 0; i < 24; i++)
			if (m[i])
				lz = 5'(23 - i);
		u.m = m << lz;
		if (a[30:23] != 8'd0)
			u.e = $signed({2'b00, a[30:23]});
		else
			u.e = 10'sd1 - $signed({5'd0, lz});
		return u;
	endfunction

	// IEEE single-precision multiply.
	function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
		logic        s;
		logic        inf_a;
		logic        inf_b;
		logic        zero_a;
		logic        zero_b;
		unp_t        ua;
		unp_t        ub;
		logic [47:0] prod;
		s      = a[31] ^ b[31];
		inf_a  = (a[30:0] == F_INF[30:0]);
		inf_b  = (b[30:0] == F_INF[30:0]);
		zero_a = (a[30:0] == 31'd0);
		zero_b = (b[30:0] == 31'd0);
		if (f_is_nan(a))
			return {a[31:23], a[22:0] | F_QUIET};
		if (f_is_nan(b))
			return {b[31:23], b[22:0] | F_QUIET};
		if ((inf_a && zero_b) || (zero_a && inf_b))
			return F_DEF_NAN;
		if (inf_a || inf_b)
			return {s, F_INF[30:0]};
		if (zero_a || zero_b)
			return {s, 31'd0};
		ua   = f_norm(a);
		ub   = f_norm(b);
		prod = ua.m * ub.m;
		if (prod[47])
			return f_pack(s, ua.e + ub.e - 10'sd126, prod[47:22], |prod[21:0]);
		return f_pack(s, ua.e + ub.e - 10'sd127, prod[46:21], |prod[20:0]);
	endfunction

	// IEEE single-precision add.
	function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
		logic        inf_a;
		logic        inf_b;
		logic        zero_a;
		logic        zero_b;
		logic        swap;
		logic [31:0] big;
		logic [31:0] sml;
		logic [7:0]  eb;
		logic [7:0]  es;
		logic [7:0]  d;
		logic [4:0]  dd;
		logic [53:0] ext;
		logic [26:0] al;
		logic [26:0] mb;
		logic [27:0] sum;
		logic [26:0] sh;
		logic [4:0]  lz;
		inf_a  = (a[30:0] == F_INF[30:0]);
		inf_b  = (b[30:0] == F_INF[30:0]);
		zero_a = (a[30:0] == 31'd0);
		zero_b = (b[30:0] == 31'd0);
		if (f_is_nan(a))
			return {a[31:23], a[22:0] | F_QUIET};
		if (f_is_nan(b))
			return {b[31:23], b[22:0] | F_QUIET};
		if (inf_a && inf_b && (a[31] != b[31]))
			return F_DEF_NAN;
		if (inf_a)
			return a;
		if (inf_b)
			return b;
		if (zero_a && zero_b)
			return {a[31] & b[31], 31'd0};
		if (zero_a)
			return b;
		if (zero_b)
			return a;
		// Order by magnitude and align the smaller operand with sticky.
		swap = (b[30:0] > a[30:0]);
		big  = swap ? b : a;
		sml  = swap ? a : b;
		eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d    = eb - es;
		dd   = (d > 8'd27) ? 5'd27 : d[4:0];
		ext  = {sml[30:23] != 8'd0, sml[22:0], 3'd0, 27'd0} >> dd;
		al   = {ext[53:28], ext[27] | (|ext[26:0])};
		mb   = {big[30:23] != 8'd0, big[22:0], 3'd0};
		if (big[31] != sml[31])
			sum = {1'b0, mb} - {1'b0, al};
		else
			sum = {1'b0, mb} + {1'b0, al};
		if (sum == 28'd0)
			return F_ZERO;
		if (sum[27])
			return f_pack(big[31], $signed({2'b00, eb}) + 10'sd1, sum[27:2], |sum[1:0]);
		// Normalize after cancellation.
		lz = 5'd0;
		for (int i = 0; i < 27; i++)
			if (sum[i])
				lz = 5'(26 - i);
		sh = sum[26:0] << lz;
		return f_pack(big[31], $signed({2'b00, eb}) - $signed({5'd0, lz}), sh[26:1], sh[0]);
	endfunction

	// Float to integer, truncating toward zero; inputs stay well below 512.
	function automatic logic signed [9:0] f_trunc(input logic [31:0] t);
		logic [7:0]  sh;
		logic [23:0] m;
		logic [8:0]  mag;
		if (t[30:23] < 8'd127) begin
			mag = 9'd0;
		end else if (t[30:23] > 8'd134) begin
			mag = 9'h1FF;
		end else begin
			sh  = 8'd150 - t[30:23];
			m   = {1'b1, t[22:0]} >> sh;
			mag = m[8:0];
		end
		if (t[31])
			return -$signed({1'b0, mag});
		return $signed({1'b0, mag});
	endfunction

	// Small integer to float, always exact.
	function automatic logic [31:0] f_itof(input logic signed [9:0] k);
		logic [9:0]  neg;
		logic [8:0]  mag;
		logic [3:0]  pos;
		logic [31:0] m32;
		neg = -k;
		mag = k[9] ? neg[8:0] : k[8:0];
		pos = 4'd0;
		for (int i = 0; i < 9; i++)
			if (mag[i])
				pos = 4'(i);
		m32 = {23'd0, mag} << (5'd23 - {1'b0, pos});
		if (mag == 9'd0)
			return F_ZERO;
		return {k[9], 8'd127 + {4'd0, pos}, m32[22:0]};
	endfunction

	// 2^k for k in the normal exponent range.
	function automatic logic [31:0] f_pow2(input logic signed [9:0] k);
		logic [9:0] e;
		e = 10'(k + 10'sd127);
		return {1'b0, e[7:0], 23'd0};
	endfunction

	// Polynomial coefficients of the exponential, after the 1/720 seed.
	function automatic logic [31:0] f_coef(input logic [2:0] j);
		logic [31:0] c;
		unique case (j)
			3'd0:    c = 32'h3C08_8889;
			3'd1:    c = 32'h3D2A_AAAB;
			3'd2:    c = 32'h3E2A_AAAB;
			3'd3:    c = F_HALF;
			default: c = F_ONE;
		endcase
		return c;
	endfunction

endpackage

// File: sv/mlp3s_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing; used for the weight and bias memory.
module mlp3s_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle: a registered read, and a write as well when we is high.
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

// File: sv/mlp_three_input_sigmoid_predict_top.sv
// Three-input, one-hidden-layer perceptron with logistic activation.
// A write word leaves busy low. A predict word raises busy while it works through
// each hidden neuron in use, taking a shorter path when the exponential saturates.
// Its speed is set by the shared float multiplier and adder and the
// one-bit-per-cycle reciprocal divider. A count of zero answers the next cycle.
// Reset clears the sequencer, sets hidden_count to 8 and the output bias to +0.0.
module mlp_three_input_sigmoid_predict_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [1:0]  weight_kind,
	input  logic [5:0]  weight_index,
	input  logic [31:0] weight_value,
	input  logic [31:0] first_input,
	input  logic [31:0] second_input,
	input  logic [31:0] third_input,
	output logic        done,
	output logic [31:0] prediction,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mlp3s_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_W0, ST_A0, ST_A1, ST_A2, ST_A3,
		ST_X0, ST_X1, ST_X2, ST_X3, ST_X4, ST_X5,
		ST_PM, ST_PA, ST_SC1, ST_SC2, ST_D1,
		ST_DV0, ST_DVI, ST_DVF, ST_OM, ST_OA
	} state_t;

	state_t             state_q;
	logic [4:0]         hc_q;
	logic [31:0]        obias_q;
	logic [31:0]        x0_q, x1_q, x2_q;
	logic [31:0]        acc_q, s_q, t_q, r_q, p_q, kf_q, hb_q, ow_q, a_q, d_q;
	logic signed [9:0]  k_q;
	logic [2:0]         j_q;
	logic [CNT_W-1:0]   n_q, cnt_q;
	logic [RAM_AW-1:0]  wa_q;
	logic [25:0]        rem_q;
	logic [23:0]        md_q;
	logic [26:0]        q_q;
	logic [4:0]         it_q;
	logic               done_q;
	logic [31:0]        pred_q;

	logic               go;
	logic               ram_we;
	logic [RAM_AW-1:0]  ram_waddr, ram_raddr, ram_addr;
	logic [31:0]        ram_rdata;
	logic [31:0]        mul_a, mul_b, mul_y, add_a, add_b, add_y;
	logic [31:0]        xe;
	logic [4:0]         cnt_in;
	logic               cfg_we;
	logic               wr_ok;
	logic [CNT_W-1:0]   n_next;
	logic [25:0]        rem_sub;
	logic               rem_ge;
	logic               half_pos;
	logic signed [9:0]  k_tr;
	logic signed [9:0]  d_exp;

	assign busy       = (state_q != ST_IDLE);
	assign go         = start & ~busy;
	assign done       = done_q;
	assign prediction = pred_q;
	assign pready     = 1'b1;
	assign xe         = {~s_q[31], s_q[30:0]};
	assign n_next     = n_q + 1'b1;
	assign cnt_in     = (hc_q > 5'(MAX_HIDDEN)) ? 5'(MAX_HIDDEN) : hc_q;
	assign half_pos   = ~t_q[31] | (t_q[30:0] == 31'd0);
	assign k_tr       = f_trunc(t_q);
	assign d_exp      = (d_q[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, d_q[30:23]});

	// Configuration port.
	assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_HIDDEN_COUNT);
	always_comb begin
		if (paddr[2] == REG_HIDDEN_COUNT)
			prdata = {27'd0, hc_q};
		else
			prdata = 32'd0;
	end

	// Weight memory write decode; out-of-range indexes are dropped.
	always_comb begin
		wr_ok     = 1'b0;
		ram_waddr = '0;
		unique case (kind_t'(weight_kind))
			KIND_HID_WEIGHT: begin
				wr_ok     = (weight_index < 6'(HW_DEPTH));
				ram_waddr = RAM_AW'(weight_index);
			end
			KIND_HID_BIAS: begin
				wr_ok     = (weight_index < 6'(MAX_HIDDEN));
				ram_waddr = RAM_AW'(HB_BASE) + RAM_AW'(weight_index);
			end
			KIND_OUT_WEIGHT: begin
				wr_ok     = (weight_index < 6'(MAX_HIDDEN));
				ram_waddr = RAM_AW'(OW_BASE) + RAM_AW'(weight_index);
			end
			KIND_OUT_BIAS: begin
				wr_ok     = 1'b0;
				ram_waddr = '0;
			end
		endcase
	end

	// Read address issued in the state before the one that uses the data.
	always_comb begin
		unique case (state_q)
			ST_W0:   ram_raddr = wa_q + RAM_AW'(1);
			ST_A0:   ram_raddr = wa_q + RAM_AW'(2);
			ST_A1:   ram_raddr = RAM_AW'(HB_BASE) + RAM_AW'(n_q);
			ST_A2:   ram_raddr = RAM_AW'(OW_BASE) + RAM_AW'(n_q);
			ST_OA:   ram_raddr = wa_q + RAM_AW'(INPUT_COUNT);
			default: ram_raddr = '0;
		endcase
	end

	assign ram_we   = go & (cmd == CMD_WRITE) & wr_ok;
	assign ram_addr = ram_we ? ram_waddr : ram_raddr;

	mlp3s_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (weight_value),
		.rdata (ram_rdata)
	);

	// Operand selection for the shared multiplier and adder.
	always_comb begin
		mul_a = F_ZERO;
		mul_b = F_ZERO;
		add_a = F_ZERO;
		add_b = F_ZERO;
		unique case (state_q)
			ST_W0: begin
				mul_a = ram_rdata; mul_b = x0_q;
			end
			ST_A0: begin
				add_a = F_ZERO; add_b = t_q;
				mul_a = ram_rdata; mul_b = x1_q;
			end
			ST_A1: begin
				add_a = s_q; add_b = t_q;
				mul_a = ram_rdata; mul_b = x2_q;
			end
			ST_A2: begin
				add_a = s_q; add_b = t_q;
			end
			ST_A3: begin
				add_a = s_q; add_b = hb_q;
			end
			ST_X0: begin
				mul_a = xe; mul_b = F_LOG2E;
			end
			ST_X1: begin
				add_a = t_q; add_b = half_pos ? F_HALF : F_NHALF;
			end
			ST_X3: begin
				mul_a = kf_q; mul_b = F_LN2_HI;
			end
			ST_X4: begin
				add_a = xe; add_b = {~t_q[31], t_q[30:0]};
				mul_a = kf_q; mul_b = F_LN2_LO;
			end
			ST_X5: begin
				add_a = r_q; add_b = {~t_q[31], t_q[30:0]};
			end
			ST_PM: begin
				mul_a = p_q; mul_b = r_q;
			end
			ST_PA: begin
				add_a = p_q; add_b = f_coef(j_q);
			end
			ST_SC1: begin
				mul_a = p_q;
				if (k_q > 10'sd127)
					mul_b = F_P2_127;
				else if (k_q < -10'sd126)
					mul_b = F_P2_M126;
				else
					mul_b = f_pow2(k_q);
			end
			ST_SC2: begin
				mul_a = p_q;
				if (k_q > 10'sd127)
					mul_b = f_pow2(k_q - 10'sd127);
				else
					mul_b = f_pow2(k_q + 10'sd126);
			end
			ST_D1: begin
				add_a = F_ONE; add_b = p_q;
			end
			ST_OM: begin
				mul_a = ow_q; mul_b = a_q;
			end
			ST_OA: begin
				add_a = acc_q; add_b = t_q;
			end
			default: begin
				mul_a = F_ZERO;
			end
		endcase
	end

	assign mul_y = f_mul(mul_a, mul_b);
	assign add_y = f_add(add_a, add_b);

	// Restoring division step of the reciprocal.
	assign rem_ge  = (rem_q >= {2'b00, md_q});
	assign rem_sub = rem_ge ? (rem_q - {2'b00, md_q}) : rem_q;

	// Sequencer, datapath registers and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hc_q    <= HIDDEN_COUNT_RESET;
			obias_q <= F_ZERO;
			done_q  <= 1'b0;
			pred_q  <= F_ZERO;
			x0_q    <= F_ZERO;
			x1_q    <= F_ZERO;
			x2_q    <= F_ZERO;
			acc_q   <= F_ZERO;
			s_q     <= F_ZERO;
			t_q     <= F_ZERO;
			r_q     <= F_ZERO;
			p_q     <= F_ZERO;
			kf_q    <= F_ZERO;
			hb_q    <= F_ZERO;
			ow_q    <= F_ZERO;
			a_q     <= F_ZERO;
			d_q     <= F_ZERO;
			k_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			cnt_q   <= '0;
			wa_q    <= '0;
			rem_q   <= '0;
			md_q    <= '0;
			q_q     <= '0;
			it_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we)
				hc_q <= pwdata[4:0];
			unique case (state_q)
				ST_IDLE: begin
					if (go && (cmd == CMD_WRITE) &&
							(kind_t'(weight_kind) == KIND_OUT_BIAS))
						obias_q <= weight_value;
					if (go && (cmd == CMD_PREDICT)) begin
						if (cnt_in == 5'd0) begin
							pred_q <= F_ZERO;
							done_q <= 1'b1;
						end else begin
							x0_q    <= first_input;
							x1_q    <= second_input;
							x2_q    <= third_input;
							acc_q   <= obias_q;
							cnt_q   <= CNT_W'(cnt_in);
							n_q     <= '0;
							wa_q    <= '0;
							state_q <= ST_W0;
						end
					end
				end
				ST_W0: begin
					t_q     <= mul_y;
					state_q <= ST_A0;
				end
				ST_A0: begin
					s_q     <= add_y;
					t_q     <= mul_y;
					state_q <= ST_A1;
				end
				ST_A1: begin
					s_q     <= add_y;
					t_q     <= mul_y;
					state_q <= ST_A2;
				end
				ST_A2: begin
					s_q     <= add_y;
					hb_q    <= ram_rdata;
					state_q <= ST_A3;
				end
				ST_A3: begin
					s_q     <= add_y;
					ow_q    <= ram_rdata;
					state_q <= ST_X0;
				end
				// Exponential of the negated sum: range checks first.
				ST_X0: begin
					if (f_is_nan(xe)) begin
						p_q     <= xe;
						state_q <= ST_D1;
					end else if (!xe[31] && (xe[30:0] > F_EXP_MAX[30:0])) begin
						p_q     <= F_INF;
						state_q <= ST_D1;
					end else if (xe[31] && (xe[30:0] > F_EXP_MIN[30:0])) begin
						p_q     <= F_ZERO;
						state_q <= ST_D1;
					end else begin
						t_q     <= mul_y;
						state_q <= ST_X1;
					end
				end
				ST_X1: begin
					t_q     <= add_y;
					state_q <= ST_X2;
				end
				ST_X2: begin
					k_q     <= k_tr;
					kf_q    <= f_itof(k_tr);
					state_q <= ST_X3;
				end
				ST_X3: begin
					t_q     <= mul_y;
					state_q <= ST_X4;
				end
				ST_X4: begin
					r_q     <= add_y;
					t_q     <= mul_y;
					state_q <= ST_X5;
				end
				ST_X5: begin
					r_q     <= add_y;
					p_q     <= F_C720;
					j_q     <= '0;
					state_q <= ST_PM;
				end
				// Horner evaluation of the degree-6 polynomial.
				ST_PM: begin
					p_q     <= mul_y;
					state_q <= ST_PA;
				end
				ST_PA: begin
					p_q <= add_y;
					j_q <= j_q + 3'd1;
					if (j_q == 3'd5)
						state_q <= ST_SC1;
					else
						state_q <= ST_PM;
				end
				// Scale by 2^k, in two steps when k leaves the normal range.
				ST_SC1: begin
					p_q <= mul_y;
					if ((k_q > 10'sd127) || (k_q < -10'sd126))
						state_q <= ST_SC2;
					else
						state_q <= ST_D1;
				end
				ST_SC2: begin
					p_q     <= mul_y;
					state_q <= ST_D1;
				end
				ST_D1: begin
					d_q     <= add_y;
					state_q <= ST_DV0;
				end
				// Reciprocal of the denominator, which is at least one.
				ST_DV0: begin
					if (f_is_nan(d_q)) begin
						a_q     <= {d_q[31:23], d_q[22:0] | F_QUIET};
						state_q <= ST_OM;
					end else if (d_q[30:23] == 8'hFF) begin
						a_q     <= F_ZERO;
						state_q <= ST_OM;
					end else begin
						rem_q   <= 26'h080_0000;
						md_q    <= {d_q[30:23] != 8'd0, d_q[22:0]};
						it_q    <= '0;
						state_q <= ST_DVI;
					end
				end
				ST_DVI: begin
					q_q   <= {q_q[25:0], rem_ge};
					rem_q <= {rem_sub[24:0], 1'b0};
					it_q  <= it_q + 5'd1;
					if (it_q == 5'd26)
						state_q <= ST_DVF;
				end
				ST_DVF: begin
					if (q_q[26])
						a_q <= f_pack(1'b0, 10'sd254 - d_exp, q_q[26:1],
							q_q[0] | (rem_q != 26'd0));
					else
						a_q <= f_pack(1'b0, 10'sd253 - d_exp, q_q[25:0], rem_q != 26'd0);
					state_q <= ST_OM;
				end
				ST_OM: begin
					t_q     <= mul_y;
					state_q <= ST_OA;
				end
				// Accumulate and step to the next neuron or finish.
				ST_OA: begin
					acc_q <= add_y;
					n_q   <= n_next;
					wa_q  <= wa_q + RAM_AW'(INPUT_COUNT);
					if (n_next == cnt_q) begin
						pred_q  <= add_y;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_W0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: dv/mlp_three_input_sigmoid_predict_top_test.sv
// Self-checking testbench for the three-input sigmoid perceptron top level.
// Depends on mlp3s_pkg and mlp_three_input_sigmoid_predict_top; predicts each result itself.
`timescale 1ns / 100ps

module mlp_three_input_sigmoid_predict_top_test;
	import mlp3s_pkg::*;

	// One command word as presented on the input ports.
	typedef struct {
		logic        op;
		kind_t       kind;
		logic [5:0]  idx;
		logic [31:0] val;
		logic [31:0] x0;
		logic [31:0] x1;
		logic [31:0] x2;
	} net_word_t;

	localparam logic [31:0] SP_ZERO   = 32'h0000_0000;
	localparam logic [31:0] SP_ONE    = 32'h3F80_0000;
	localparam logic [31:0] SP_HALF   = 32'h3F00_0000;
	localparam logic [31:0] SP_NHALF  = 32'hBF00_0000;
	localparam logic [31:0] SP_LOG2E  = 32'h3FB8_AA3B;
	localparam logic [31:0] SP_LN2HI  = 32'h3F31_7200;
	localparam logic [31:0] SP_LN2LO  = 32'h35BF_BE8E;
	localparam logic [31:0] SP_EXPHI  = 32'h42B1_7213;
	localparam logic [31:0] SP_EXPLO  = 32'hC2D0_0000;
	localparam logic [31:0] SP_INF    = 32'h7F80_0000;
	localparam logic [31:0] SP_DNAN   = 32'hFFC0_0000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cmd;
	logic [1:0]  weight_kind;
	logic [5:0]  weight_index;
	logic [31:0] weight_value;
	logic [31:0] first_input;
	logic [31:0] second_input;
	logic [31:0] third_input;
	logic        done;
	logic [31:0] prediction;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mlp_three_input_sigmoid_predict_top uut (.*);

	// Predictor state: the weight stores and the active neuron count.
	logic [31:0] hid_w_mem [HW_DEPTH];
	logic [31:0] hid_b_mem [MAX_HIDDEN];
	logic [31:0] out_w_mem [MAX_HIDDEN];
	logic [31:0] out_bias;
	logic [4:0]  active_count;

	net_word_t   word_q[$];
	logic [31:0] pending_predictions[$];
	bit          took_word;
	bit          quiet_mode;
	int          gap_left;
	int          fault_count;
	int          accepted_words;
	int          predict_words;
	int          settings_used;

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Single-precision helpers. Products, sums and quotients of two singles are
	// formed exactly enough in double precision that one rounding to single is correct.
	function automatic bit sp_nan(logic [31:0] f);
		return (f[30:23] == 8'hFF) && (f[22:0] != 0);
	endfunction

	function automatic bit sp_inf(logic [31:0] f);
		return f[30:0] == SP_INF[30:0];
	endfunction

	function automatic logic [31:0] sp_quiet(logic [31:0] f);
		return {f[31:23], f[22] | 1'b1, f[21:0]};
	endfunction

	function automatic real sp_to_real(logic [31:0] f);
		logic [23:0] mm;
		int          e;
		if (f[30:0] == 0)
			return $bitstoreal({f[31], 63'd0});
		mm = {1'b0, f[22:0]};
		e  = f[30:23];
		if (e == 0) begin
			e = 1;
			while (!mm[23]) begin
				mm = mm << 1;
				e  = e - 1;
			end
			return $bitstoreal({f[31], 11'(e + 896), mm[22:0], 29'd0});
		end
		return $bitstoreal({f[31], 11'(e + 896), f[22:0], 29'd0});
	endfunction

	// Round a double to single precision, nearest even, with subnormals.
	function automatic logic [31:0] real_to_sp(real r);
		logic [63:0]  d;
		logic [127:0] v;
		logic [23:0]  kept;
		logic [30:0]  fld;
		logic         up;
		int           eb;
		int           sh;
		d = $realtobits(r);
		if (d[62:0] == 0)
			return {d[63], 31'd0};
		eb = int'(d[62:52]) - 896;
		if (eb >= 255)
			return {d[63], SP_INF[30:0]};
		sh = (eb >= 1) ? 0 : 1 - eb;
		if (sh > 100)
			sh = 100;
		v    = {1'b1, d[51:0], 75'd0} >> sh;
		kept = v[127:104];
		fld  = (eb >= 1) ? {eb[7:0], kept[22:0]} : {8'd0, kept[22:0]};
		up   = v[103] & ((|v[102:0]) | fld[0]);
		return {d[63], fld + 31'(up)};
	endfunction

	function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
		if (sp_nan(a))
			return sp_quiet(a);
		if (sp_nan(b))
			return sp_quiet(b);
		if ((sp_inf(a) && b[30:0] == 0) || (sp_inf(b) && a[30:0] == 0))
			return SP_DNAN;
		if (sp_inf(a) || sp_inf(b))
			return {a[31] ^ b[31], SP_INF[30:0]};
		if (a[30:0] == 0 || b[30:0] == 0)
			return {a[31] ^ b[31], 31'd0};
		return real_to_sp(sp_to_real(a) * sp_to_real(b));
	endfunction

	function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
		real r;
		if (sp_nan(a))
			return sp_quiet(a);
		if (sp_nan(b))
			return sp_quiet(b);
		if (sp_inf(a) && sp_inf(b) && a[31] != b[31])
			return SP_DNAN;
		if (sp_inf(a))
			return a;
		if (sp_inf(b))
			return b;
		if (a[30:0] == 0 && b[30:0] == 0)
			return {a[31] & b[31], 31'd0};
		if (a[30:0] == 0)
			return b;
		if (b[30:0] == 0)
			return a;
		r = sp_to_real(a) + sp_to_real(b);
		if (r == 0.0)
			return SP_ZERO;
		return real_to_sp(r);
	endfunction

	function automatic logic [31:0] sp_neg(logic [31:0] a);
		return {~a[31], a[30:0]};
	endfunction

	function automatic logic [31:0] sp_recip(logic [31:0] d);
		if (sp_nan(d))
			return sp_quiet(d);
		if (sp_inf(d))
			return {d[31], 31'd0};
		if (d[30:0] == 0)
			return {d[31], SP_INF[30:0]};
		return real_to_sp(1.0 / sp_to_real(d));
	endfunction

	// Exponential: reduction by ln2 in two parts, degree-6 polynomial, 2^k scaling.
	function automatic logic [31:0] sp_exp(logic [31:0] x);
		logic [31:0] t;
		logic [31:0] r;
		logic [31:0] p;
		logic [31:0] kf;
		logic [31:0] coef [6];
		int          k;
		coef = '{32'h3C08_8889, 32'h3D2A_AAAB, 32'h3E2A_AAAB, SP_HALF, SP_ONE, SP_ONE};
		if (sp_nan(x))
			return x;
		if (sp_inf(x))
			return x[31] ? SP_ZERO : SP_INF;
		if (sp_to_real(x) > sp_to_real(SP_EXPHI))
			return SP_INF;
		if (sp_to_real(x) < sp_to_real(SP_EXPLO))
			return SP_ZERO;
		t  = sp_mul(x, SP_LOG2E);
		t  = sp_add(t, (sp_to_real(t) >= 0.0) ? SP_HALF : SP_NHALF);
		k  = $rtoi(sp_to_real(t));
		kf = real_to_sp(real'(k));
		r  = sp_add(x, sp_neg(sp_mul(kf, SP_LN2HI)));
		r  = sp_add(r, sp_neg(sp_mul(kf, SP_LN2LO)));
		p  = 32'h3AB6_0B61;
		for (int j = 0; j < 6; j++)
			p = sp_add(sp_mul(p, r), coef[j]);
		if (k > 127)
			return sp_mul(sp_mul(p, {1'b0, 8'd254, 23'd0}), {1'b0, 8'(k), 23'd0});
		if (k < -126)
			return sp_mul(sp_mul(p, {1'b0, 8'd1, 23'd0}), {1'b0, 8'(k + 253), 23'd0});
		return sp_mul(p, {1'b0, 8'(k + 127), 23'd0});
	endfunction

	// Network output for one set of inputs under the current stores.
	function automatic logic [31:0] net_forward(logic [31:0] x0, logic [31:0] x1,
			logic [31:0] x2);
		logic [31:0] xs [3];
		logic [31:0] acc;
		logic [31:0] s;
		logic [31:0] act;
		int          n_used;
		xs     = '{x0, x1, x2};
		n_used = (active_count > MAX_HIDDEN) ? MAX_HIDDEN : active_count;
		if (n_used == 0)
			return SP_ZERO;
		acc = out_bias;
		for (int n = 0; n < n_used; n++) begin
			s = SP_ZERO;
			for (int i = 0; i < INPUT_COUNT; i++)
				s = sp_add(s, sp_mul(hid_w_mem[n * INPUT_COUNT + i], xs[i]));
			s   = sp_add(s, hid_b_mem[n]);
			act = sp_recip(sp_add(SP_ONE, sp_exp(sp_neg(s))));
			acc = sp_add(acc, sp_mul(out_w_mem[n], act));
		end
		return acc;
	endfunction

	// Store update for an accepted write word; out-of-range indexes are dropped.
	function automatic void store_weight(net_word_t w);
		case (w.kind)
			KIND_HID_WEIGHT: if (w.idx < HW_DEPTH) hid_w_mem[w.idx] = w.val;
			KIND_HID_BIAS:   if (w.idx < MAX_HIDDEN) hid_b_mem[w.idx] = w.val;
			KIND_OUT_WEIGHT: if (w.idx < MAX_HIDDEN) out_w_mem[w.idx] = w.val;
			default:         out_bias = w.val;
		endcase
	endfunction

	function automatic logic [31:0] special_float();
		logic [31:0] specials [10];
		specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'h7F80_0001, 32'h7F7F_FFFF, 32'h0000_0001,
			32'h3F80_0000, 32'hBF80_0000};
		return specials[$urandom_range(0, 9)];
	endfunction

	// Mostly moderate magnitudes so the sigmoid is exercised, with a few odd patterns.
	function automatic logic [31:0] pick_float(int odd_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < odd_pct / 3)
			return special_float();
		if (r < odd_pct)
			return $urandom;
		return {1'($urandom), 8'($urandom_range(118, 130)), 23'($urandom)};
	endfunction

	function automatic net_word_t make_write(kind_t kind, logic [5:0] idx, logic [31:0] val);
		net_word_t w;
		w.op   = CMD_WRITE;
		w.kind = kind;
		w.idx  = idx;
		w.val  = val;
		w.x0   = $urandom;
		w.x1   = $urandom;
		w.x2   = $urandom;
		return w;
	endfunction

	function automatic net_word_t make_predict(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		net_word_t w;
		w.op   = CMD_PREDICT;
		w.kind = kind_t'($urandom_range(0, 3));
		w.idx  = 6'($urandom);
		w.val  = $urandom;
		w.x0   = a;
		w.x1   = b;
		w.x2   = c;
		return w;
	endfunction

	function automatic net_word_t random_word();
		kind_t kind;
		int    r;
		r    = $urandom_range(0, 99);
		kind = kind_t'($urandom_range(0, 3));
		if (r < 45)
			return make_predict(pick_float(20), pick_float(20), pick_float(20));
		if (r < 90)
			return make_write(kind, 6'($urandom_range(0, (kind == KIND_HID_WEIGHT) ?
				HW_DEPTH - 1 : MAX_HIDDEN - 1)), pick_float(8));
		return make_write(kind, 6'($urandom), $urandom);
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Driver: presents queued words at the falling edge and holds each until taken.
	always @(negedge clk) begin
		net_word_t w;
		if (!(start && !took_word)) begin
			took_word = 0;
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (word_q.size() > 0) begin
				w = word_q.pop_front();
				cmd          <= w.op;
				weight_kind  <= w.kind;
				weight_index <= w.idx;
				weight_value <= w.val;
				first_input  <= w.x0;
				second_input <= w.x1;
				third_input  <= w.x2;
				start        <= 1'b1;
				gap_left     = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each result strobe, predicts each accepted predict word and applies each write.
	always @(posedge clk) begin
		net_word_t   w;
		logic [31:0] want;
		if (arst_n) begin
			if (done) begin
				if (pending_predictions.size() == 0) begin
					$display("%0t: unexpected prediction, expected none, actual %08h",
						$time, prediction);
					fault_count++;
				end else begin
					want = pending_predictions.pop_front();
					if (prediction !== want) begin
						$display("%0t: prediction mismatch, expected %08h, actual %08h",
							$time, want, prediction);
						fault_count++;
					end
				end
			end
			if (start && !busy) begin
				took_word = 1;
				accepted_words++;
				w.op   = cmd;
				w.kind = kind_t'(weight_kind);
				w.idx  = weight_index;
				w.val  = weight_value;
				if (cmd == CMD_PREDICT) begin
					predict_words++;
					pending_predictions.push_back(net_forward(first_input, second_input,
						third_input));
				end else begin
					store_weight(w);
				end
			end
		end
	end

	// Waits until every queued word is taken and every result has arrived.
	task automatic drain();
		wait (word_q.size() == 0 && !start && pending_predictions.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_hidden_count(logic [4:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= {REG_HIDDEN_COUNT, 2'b00};
		pwdata  <= {27'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		active_count = value;
		settings_used++;
	endtask

	task automatic run_phase(logic [4:0] count_value, int n_words);
		drain();
		set_hidden_count(count_value);
		quiet_mode = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n_words; i++)
			word_q.push_back(random_word());
	endtask

	initial begin
		logic [4:0] counts [8];
		counts         = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd3, 5'd2, 5'd17, 5'd8};
		clk            = 0;
		arst_n         = 0;
		start          = 0;
		cmd            = CMD_WRITE;
		weight_kind    = KIND_HID_WEIGHT;
		weight_index   = 0;
		weight_value   = 0;
		first_input    = 0;
		second_input   = 0;
		third_input    = 0;
		psel           = 0;
		penable        = 0;
		pwrite         = 0;
		paddr          = 0;
		pwdata         = 0;
		took_word      = 0;
		gap_left       = 0;
		quiet_mode     = 0;
		fault_count    = 0;
		accepted_words = 0;
		predict_words  = 0;
		settings_used  = 1;
		active_count   = HIDDEN_COUNT_RESET;
		out_bias       = SP_ZERO;
		foreach (hid_w_mem[i])
			hid_w_mem[i] = SP_ZERO;
		foreach (hid_b_mem[i]) begin
			hid_b_mem[i] = SP_ZERO;
			out_w_mem[i] = SP_ZERO;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Load every entry before the first prediction can read it.
		for (int i = 0; i < HW_DEPTH; i++)
			word_q.push_back(make_write(KIND_HID_WEIGHT, 6'(i), pick_float(0)));
		for (int i = 0; i < MAX_HIDDEN; i++) begin
			word_q.push_back(make_write(KIND_HID_BIAS, 6'(i), pick_float(0)));
			word_q.push_back(make_write(KIND_OUT_WEIGHT, 6'(i), pick_float(0)));
		end
		word_q.push_back(make_write(KIND_OUT_BIAS, 6'd0, pick_float(0)));

		// Directed words at the reset count: extreme inputs, ignored writes,
		// and first-layer weights that saturate the exponential both ways.
		word_q.push_back(make_predict(32'h0000_0000, 32'h8000_0000, 32'h0000_0000));
		word_q.push_back(make_predict(32'h7F80_0000, 32'hFF80_0000, SP_ONE));
		word_q.push_back(make_predict(32'h7FC0_0000, SP_ONE, SP_ONE));
		word_q.push_back(make_predict(32'h7F7F_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
		word_q.push_back(make_predict(32'h0080_0000, 32'h807F_FFFF, 32'h4120_0000));
		word_q.push_back(make_write(KIND_HID_WEIGHT, 6'd48, SP_DNAN));
		word_q.push_back(make_write(KIND_HID_WEIGHT, 6'd63, SP_DNAN));
		word_q.push_back(make_write(KIND_HID_BIAS, 6'd16, SP_DNAN));
		word_q.push_back(make_write(KIND_OUT_WEIGHT, 6'd63, SP_DNAN));
		word_q.push_back(make_write(KIND_OUT_BIAS, 6'd63, 32'hC000_0000));
		word_q.push_back(make_predict(SP_ONE, SP_ONE, SP_ONE));
		word_q.push_back(make_write(KIND_HID_WEIGHT, 6'd0, 32'h7F7F_FFFF));
		word_q.push_back(make_predict(SP_ONE, SP_ZERO, SP_ZERO));
		word_q.push_back(make_predict(32'hBF80_0000, SP_ZERO, SP_ZERO));
		word_q.push_back(make_write(KIND_HID_BIAS, 6'd15, 32'h7F80_0000));
		word_q.push_back(make_predict(SP_HALF, SP_HALF, SP_HALF));
		word_q.push_back(make_write(KIND_HID_WEIGHT, 6'd0, SP_ONE));
		word_q.push_back(make_write(KIND_HID_BIAS, 6'd15, SP_NHALF));
		word_q.push_back(make_write(KIND_OUT_BIAS, 6'd0, SP_ZERO));
		word_q.push_back(make_predict(SP_ONE, SP_NHALF, SP_HALF));

		// Random phases across the count settings, each started from idle.
		for (int p = 0; p < 8; p++)
			run_phase(counts[p], 55);
		run_phase(5'($urandom_range(0, 31)), 10);
		drain();
		repeat (20) @(posedge clk);

		$display("Covered %0d words, %0d of them predictions, over %0d hidden-count settings.",
			accepted_words, predict_words, settings_used);
		if (fault_count == 0 && pending_predictions.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#30_000_000;
		$display("Timeout with %0d predictions outstanding.", pending_predictions.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
